// ===== rtl/core/ycc2rgb_pkg.sv =====
// Shared types and constants for the YCbCr to RGB converter.
// Used by ycc2rgb_mulhi and ycbcr_to_rgb_convert_top; no dependencies.
package ycc2rgb_pkg;

   localparam int PIX_W  = 8;   // one color sample
   localparam int GAIN_W = 16;  // Q16 fractional gain
   localparam int OFFS_W = 9;   // sample with its offset removed
   localparam int PROD_W = OFFS_W + GAIN_W;
   localparam int MH_W   = 8;   // multiply-high result, |value| <= 120
   localparam int SUM_W  = 12;  // channel sum, |value| < 700
   localparam int NUM_REGS = 7;
   localparam int IDX_W  = 3;
   localparam int DATA_W = 3 * PIX_W;

   localparam logic signed [OFFS_W-1:0] LUMA_OFFSET   = 9'sd16;
   localparam logic signed [OFFS_W-1:0] CHROMA_OFFSET = 9'sd128;

   typedef enum logic [IDX_W-1:0] {
      REG_LUMA_FRAC_RED   = 3'd0,
      REG_LUMA_FRAC_GREEN = 3'd1,
      REG_LUMA_FRAC_BLUE  = 3'd2,
      REG_CR_FRAC_RED     = 3'd3,
      REG_CB_FRAC_GREEN   = 3'd4,
      REG_CR_FRAC_GREEN   = 3'd5,
      REG_CB_FRAC_BLUE    = 3'd6
   } reg_index_type;

   localparam logic signed [GAIN_W-1:0] RST_LUMA_FRAC = 16'sd10773;
   localparam logic signed [GAIN_W-1:0] RST_CR_FRAC_RED = 16'sd6293;
   localparam logic signed [GAIN_W-1:0] RST_CB_FRAC_GREEN = -16'sd25675;
   localparam logic signed [GAIN_W-1:0] RST_CR_FRAC_GREEN = -16'sd20511;
   localparam logic signed [GAIN_W-1:0] RST_CB_FRAC_BLUE = 16'sd1129;

   typedef logic signed [OFFS_W-1:0] offs_type;
   typedef logic signed [GAIN_W-1:0] gain_type;
   typedef logic signed [MH_W-1:0]   mh_type;
   typedef logic signed [SUM_W-1:0]  sum_type;

endpackage

// ===== rtl/core/ycbcr_to_rgb_convert_top.sv =====
// BT.601 limited-range YCbCr to RGB converter, four register stages.
// Throughput one item per cycle while the output is not stalled.
// Stages: offset removal, seven Q16 multiply-highs, channel sums, clamp to 0..255.
// Each stage holds its item while the next stage cannot take it, so bubbles close up under stall.
// Synchronous reset empties the pipeline and loads the default gains.
module ycbcr_to_rgb_convert_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // luma [7:0], chroma_blue [15:8], chroma_red [23:16]
   input  logic [ycc2rgb_pkg::DATA_W-1:0]  req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // red [7:0], green [15:8], blue [23:16]
   output logic [ycc2rgb_pkg::DATA_W-1:0]  rsp_tdata,
   input  logic                            csr_we,
   input  logic [ycc2rgb_pkg::IDX_W-1:0]   csr_index,
   input  logic [ycc2rgb_pkg::GAIN_W-1:0]  csr_wdata
);
   import ycc2rgb_pkg::*;

   // Gain registers
   gain_type lfr_ff, lfg_ff, lfb_ff, crr_ff, cbg_ff, crg_ff, cbb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lfr_ff <= RST_LUMA_FRAC;
         lfg_ff <= RST_LUMA_FRAC;
         lfb_ff <= RST_LUMA_FRAC;
         crr_ff <= RST_CR_FRAC_RED;
         cbg_ff <= RST_CB_FRAC_GREEN;
         crg_ff <= RST_CR_FRAC_GREEN;
         cbb_ff <= RST_CB_FRAC_BLUE;
      end else if (csr_we) begin
         case (reg_index_type'(csr_index))
            REG_LUMA_FRAC_RED:   lfr_ff <= csr_wdata;
            REG_LUMA_FRAC_GREEN: lfg_ff <= csr_wdata;
            REG_LUMA_FRAC_BLUE:  lfb_ff <= csr_wdata;
            REG_CR_FRAC_RED:     crr_ff <= csr_wdata;
            REG_CB_FRAC_GREEN:   cbg_ff <= csr_wdata;
            REG_CR_FRAC_GREEN:   crg_ff <= csr_wdata;
            REG_CB_FRAC_BLUE:    cbb_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage valid bits and per-stage advance
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic v1_in, v2_in, v3_in, v4_in;
   logic rdy1, rdy2, rdy3, rdy4;

   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;

   assign v1_in = req_tvalid;
   assign v2_in = v1_ff;
   assign v3_in = v2_ff;
   assign v4_in = v3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= v1_in;
         if (rdy2) v2_ff <= v2_in;
         if (rdy3) v3_ff <= v3_in;
         if (rdy4) v4_ff <= v4_in;
      end
   end

   assign req_tready = rdy1;

   // Stage 1: remove offsets
   offs_type t1_ff, cb1_ff, cr1_ff;
   offs_type t1_in, cb1_in, cr1_in;

   assign t1_in  = offs_type'({1'b0, req_tdata[PIX_W-1:0]}) - LUMA_OFFSET;
   assign cb1_in = offs_type'({1'b0, req_tdata[2*PIX_W-1:PIX_W]}) - CHROMA_OFFSET;
   assign cr1_in = offs_type'({1'b0, req_tdata[3*PIX_W-1:2*PIX_W]}) - CHROMA_OFFSET;

   always_ff @(posedge clock) begin
      if (rdy1) begin
         t1_ff  <= t1_in;
         cb1_ff <= cb1_in;
         cr1_ff <= cr1_in;
      end
   end

   // Stage 2: multiply-highs, offsets carried along
   mh_type   mh_tr, mh_tg, mh_tb, mh_crr, mh_cbg, mh_crg, mh_cbb;
   offs_type t2_ff, cb2_ff, cr2_ff;

   ycc2rgb_mulhi u_mh_tr  (.clock(clock), .enable(rdy2), .a(t1_ff),  .b(lfr_ff), .mh(mh_tr));
   ycc2rgb_mulhi u_mh_tg  (.clock(clock), .enable(rdy2), .a(t1_ff),  .b(lfg_ff), .mh(mh_tg));
   ycc2rgb_mulhi u_mh_tb  (.clock(clock), .enable(rdy2), .a(t1_ff),  .b(lfb_ff), .mh(mh_tb));
   ycc2rgb_mulhi u_mh_crr (.clock(clock), .enable(rdy2), .a(cr1_ff), .b(crr_ff), .mh(mh_crr));
   ycc2rgb_mulhi u_mh_cbg (.clock(clock), .enable(rdy2), .a(cb1_ff), .b(cbg_ff), .mh(mh_cbg));
   ycc2rgb_mulhi u_mh_crg (.clock(clock), .enable(rdy2), .a(cr1_ff), .b(crg_ff), .mh(mh_crg));
   ycc2rgb_mulhi u_mh_cbb (.clock(clock), .enable(rdy2), .a(cb1_ff), .b(cbb_ff), .mh(mh_cbb));

   always_ff @(posedge clock) begin
      if (rdy2) begin
         t2_ff  <= t1_ff;
         cb2_ff <= cb1_ff;
         cr2_ff <= cr1_ff;
      end
   end

   // Stage 3: channel sums. The operands are small enough that no partial sum
   // ever reaches the 16-bit saturation limits, so plain adds give the same result.
   sum_type r3_ff, g3_ff, b3_ff;
   sum_type r3_in, g3_in, b3_in;
   sum_type t_x, cb_x, cr_x, half_cr;

   assign t_x     = SUM_W'(t2_ff);
   assign cb_x    = SUM_W'(cb2_ff);
   assign cr_x    = SUM_W'(cr2_ff);
   assign half_cr = cr_x >>> 1;

   assign r3_in = SUM_W'(mh_tr) + t_x + SUM_W'(mh_crr) + cr_x + half_cr;
   assign g3_in = SUM_W'(mh_tg) + t_x + SUM_W'(mh_cbg) + SUM_W'(mh_crg) - half_cr;
   assign b3_in = SUM_W'(mh_tb) + t_x + SUM_W'(mh_cbb) + (cb_x <<< 1);

   always_ff @(posedge clock) begin
      if (rdy3) begin
         r3_ff <= r3_in;
         g3_ff <= g3_in;
         b3_ff <= b3_in;
      end
   end

   // Stage 4: clamp into the output register
   function automatic logic [PIX_W-1:0] clamp8(input sum_type v);
      logic [PIX_W-1:0] res;
      if (v < 0) begin
         res = '0;
      end else if (v > SUM_W'(255)) begin
         res = '1;
      end else begin
         res = v[PIX_W-1:0];
      end
      return res;
   endfunction

   logic [DATA_W-1:0] out_ff;
   logic [DATA_W-1:0] out_in;

   assign out_in = {clamp8(b3_ff), clamp8(g3_ff), clamp8(r3_ff)};

   always_ff @(posedge clock) begin
      if (rdy4) begin
         out_ff <= out_in;
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = out_ff;

   // Checks
   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> v1_ff)
      else $error("accepted item did not enter the first stage");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && v4_ff))
      else $error("input stalled while a stage was empty");

   a_s3_holds_on_stall: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && !rsp_tready && v3_ff) |=> (v3_ff && $stable(r3_ff) && $stable(b3_ff)))
      else $error("stage three lost its item under stall");

   a_no_item_created: assert property (@(posedge clock) disable iff (reset)
      (!v3_ff && !rsp_tready && v4_ff) |=> !v3_ff || $past(v2_ff))
      else $error("stage three filled without an item upstream");

endmodule

// ===== rtl/core/ycc2rgb_mulhi.sv =====
// Registered signed Q16 multiply-high: floor(a * b / 65536).
// Depends on ycc2rgb_pkg for widths and types.
module ycc2rgb_mulhi (
   input  logic                  clock,
   input  logic                  enable,
   input  ycc2rgb_pkg::offs_type a,
   input  ycc2rgb_pkg::gain_type b,
   output ycc2rgb_pkg::mh_type   mh
);
   import ycc2rgb_pkg::*;

   logic signed [PROD_W-1:0] prod;
   mh_type                   mh_ff;
   mh_type                   mh_in;

   // Taking the bits above 16 is an arithmetic shift, so it rounds toward minus infinity.
   // The result always fits the narrow field, so the top bits are dropped.
   assign prod  = PROD_W'(a) * PROD_W'(b);
   assign mh_in = prod[GAIN_W+MH_W-1:GAIN_W];

   always_ff @(posedge clock) begin
      if (enable) begin
         mh_ff <= mh_in;
      end
   end

   assign mh = mh_ff;

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for ycbcr_to_rgb_convert_top: directed and random pixels under several
// gain settings, each result checked against an in-line BT.601 converter model.
// Depends on ycc2rgb_pkg and the converter RTL only.
module tb_top;
   import ycc2rgb_pkg::*;

   localparam int LATENCY = 4;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 220;
   localparam int MAX_REPORTS = 10;
   localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
   localparam gain_type GAIN_MAX = 16'sh7fff;
   localparam gain_type GAIN_MIN = 16'sh8000;

   localparam gain_type DEFAULT_GAINS [NUM_REGS] = '{
      RST_LUMA_FRAC, RST_LUMA_FRAC, RST_LUMA_FRAC, RST_CR_FRAC_RED,
      RST_CB_FRAC_GREEN, RST_CR_FRAC_GREEN, RST_CB_FRAC_BLUE
   };

   typedef struct packed {
      logic [PIX_W-1:0] chroma_red;
      logic [PIX_W-1:0] chroma_blue;
      logic [PIX_W-1:0] luma;
   } ycc_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } rgb_type;

   typedef enum {SET_DEFAULT, SET_MAX, SET_MIN, SET_ZERO, SET_ALTERNATE, SET_RANDOM}
      gain_set_type;

   localparam gain_set_type PHASE_PLAN [7] = '{
      SET_MAX, SET_MIN, SET_ZERO, SET_ALTERNATE, SET_RANDOM, SET_RANDOM, SET_DEFAULT
   };
   // The random phase at this position runs with no idling on either side.
   localparam int STEADY_PHASE = 4;

   // Packed as {Cr, Cb, Y}: black, white, neutral grays, chroma extremes,
   // odd Cr values around the midpoint, and the three limited-range primaries.
   localparam ycc_type DIRECTED [20] = '{
      24'h00_00_00, 24'hFF_FF_FF, 24'h80_80_10, 24'h80_80_EB, 24'h80_80_00,
      24'h80_80_FF, 24'h80_00_80, 24'h80_FF_80, 24'h00_80_80, 24'hFF_80_80,
      24'h7F_80_80, 24'h81_80_80, 24'h80_7F_80, 24'hFF_00_FF, 24'h00_FF_00,
      24'hF0_10_10, 24'h10_F0_EB, 24'hF0_5A_51, 24'h22_36_91, 24'h6E_F0_29
   };

   class rgb_scoreboard;
      gain_type gains [NUM_REGS];
      rgb_type expected_rgb [$];
      int errors;

      function new();
         gains = DEFAULT_GAINS;
         errors = 0;
      endfunction

      function void set_gain(logic [IDX_W-1:0] index, gain_type value);
         if (index < NUM_REGS) gains[index] = value;
      endfunction

      function void report_error(string what);
         errors++;
         if (errors <= MAX_REPORTS) $display("ERROR at %0t: %s", $realtime, what);
      endfunction

      static function int sat16(int v);
         if (v > 32767) return 32767;
         if (v < -32768) return -32768;
         return v;
      endfunction

      // Signed Q16 multiply-high, rounded toward minus infinity.
      static function int mul_high(int a, gain_type g);
         int p;
         p = a * int'(g);
         return p >>> 16;
      endfunction

      static function logic [PIX_W-1:0] clamp_pixel(int v);
         if (v < 0) return '0;
         if (v > 255) return 8'd255;
         return v[PIX_W-1:0];
      endfunction

      function rgb_type convert_pixel(ycc_type px);
         int t, cb, cr, r, g, b;
         rgb_type rgb;
         t = sat16(int'(px.luma) - int'(LUMA_OFFSET));
         cb = sat16(int'(px.chroma_blue) - int'(CHROMA_OFFSET));
         cr = sat16(int'(px.chroma_red) - int'(CHROMA_OFFSET));

         r = sat16(mul_high(t, gains[REG_LUMA_FRAC_RED]) + t);
         r = sat16(r + mul_high(cr, gains[REG_CR_FRAC_RED]));
         r = sat16(r + cr);
         r = sat16(r + (cr >>> 1));

         g = sat16(mul_high(t, gains[REG_LUMA_FRAC_GREEN]) + t);
         g = sat16(g + mul_high(cb, gains[REG_CB_FRAC_GREEN]));
         g = sat16(g + mul_high(cr, gains[REG_CR_FRAC_GREEN]));
         g = sat16(g - (cr >>> 1));

         b = sat16(mul_high(t, gains[REG_LUMA_FRAC_BLUE]) + t);
         b = sat16(b + mul_high(cb, gains[REG_CB_FRAC_BLUE]));
         b = sat16(b + 2 * cb);

         rgb.red = clamp_pixel(r);
         rgb.green = clamp_pixel(g);
         rgb.blue = clamp_pixel(b);
         return rgb;
      endfunction

      function void note_pixel(ycc_type px);
         expected_rgb.push_back(convert_pixel(px));
      endfunction

      function void check_rgb(rgb_type got);
         rgb_type want;
         if (expected_rgb.size() == 0) begin
            report_error($sformatf("result r=%0d g=%0d b=%0d with no pixel outstanding",
                                   got.red, got.green, got.blue));
            return;
         end
         want = expected_rgb.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
            report_error($sformatf("expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                   want.red, want.green, want.blue,
                                   got.red, got.green, got.blue));
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [DATA_W-1:0] req_tdata;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DATA_W-1:0] rsp_tdata;
   logic csr_we;
   logic [IDX_W-1:0] csr_index;
   logic [GAIN_W-1:0] csr_wdata;
   logic steady = 1'b0;
   int cycles = 0;
   rgb_scoreboard sb = new();

   ycbcr_to_rgb_convert_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= steady || ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_pixel(ycc_type'(req_tdata));
         if (rsp_tvalid && rsp_tready) sb.check_rgb(rgb_type'(rsp_tdata));
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   function automatic logic [PIX_W-1:0] edge_sample();
      case ($urandom_range(0, 5))
         0: return 8'd0;
         1: return 8'd16;
         2: return 8'd128;
         3: return 8'd235;
         4: return 8'd240;
         default: return 8'd255;
      endcase
   endfunction

   function automatic ycc_type random_pixel();
      ycc_type px;
      px = ycc_type'($urandom);
      if ($urandom_range(0, 3) == 0) px.luma = edge_sample();
      if ($urandom_range(0, 3) == 0) px.chroma_blue = edge_sample();
      if ($urandom_range(0, 3) == 0) px.chroma_red = edge_sample();
      return px;
   endfunction

   function automatic gain_type pick_gain(gain_set_type kind, int index);
      case (kind)
         SET_MAX: return GAIN_MAX;
         SET_MIN: return GAIN_MIN;
         SET_ZERO: return '0;
         SET_ALTERNATE: return index[0] ? GAIN_MIN : GAIN_MAX;
         SET_RANDOM: return gain_type'($urandom);
         default: return DEFAULT_GAINS[index];
      endcase
   endfunction

   task automatic send_pixel(input ycc_type px);
      while (!steady && $urandom_range(0, 99) < 10) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= px;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic load_gains(input gain_set_type kind);
      gain_type value;
      for (int i = 0; i < NUM_REGS; i++) begin
         value = pick_gain(kind, i);
         csr_we <= 1'b1;
         csr_index <= IDX_W'(i);
         csr_wdata <= value;
         sb.set_gain(IDX_W'(i), value);
         @(posedge clock);
      end
      // No register sits behind the spare index, so this write must change nothing.
      value = gain_type'($urandom);
      csr_we <= 1'b1;
      csr_index <= REG_UNUSED;
      csr_wdata <= value;
      sb.set_gain(REG_UNUSED, value);
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.expected_rgb.size() != 0) @(posedge clock);
      repeat (LATENCY + 2) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[k]) send_pixel(DIRECTED[k]);
      drain_pipeline();

      foreach (PHASE_PLAN[p]) begin
         load_gains(PHASE_PLAN[p]);
         steady <= (p == STEADY_PHASE);
         for (int k = 0; k < PHASE_ITEMS; k++) send_pixel(random_pixel());
         drain_pipeline();
      end

      if (sb.errors == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/ycc2rgb_pkg.sv
rtl/core/ycc2rgb_mulhi.sv
rtl/core/ycbcr_to_rgb_convert_top.sv
test/tb_top.sv
